@@ hw/rtl/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX    = 3'd2,
    MODE_LOOK   = 3'd3
  } mode_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FEED = 5'b00010,
    ST_EMIT = 5'b00100,
    ST_MARK = 5'b01000,
    ST_WAIT = 5'b10000
  } state_e;

  localparam logic [15:0] SurHiLo  = 16'hD800;
  localparam logic [15:0] SurHiHi  = 16'hDBFF;
  localparam logic [15:0] SurLoLo  = 16'hDC00;
  localparam logic [15:0] SurLoHi  = 16'hDFFF;
  localparam logic [20:0] SupBase  = 21'h10000;
  localparam logic [20:0] Replace  = 21'h00FFFD;
  localparam logic [7:0]  Lead2    = 8'hC0;
  localparam logic [7:0]  Lead3    = 8'hE0;
  localparam logic [7:0]  Lead4    = 8'hF0;
  localparam logic [7:0]  ContMark = 8'h80;
  localparam logic [7:0]  ContMask = 8'h3F;
  localparam logic [7:0]  ChBslash = 8'h5C;
  localparam logic [7:0]  ChU      = 8'h75;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueueAw    = 3;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

@@ hw/rtl/jsu_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for source bytes and result beats.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface jsu_out_if #(parameter int unsigned COUNT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [7:0]            out_byte;
  logic                  out_valid;
  logic                  out_last;
  logic [COUNT_BITS-1:0] out_count;
  modport source (output valid, out_byte, out_valid, out_last, out_count, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, out_count, output ready);
endinterface

@@ hw/rtl/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string-body unescaper with UTF-8 output.
// Each byte is decoded in the feed state, then its output beats are sent in
// the emit state, which waits while the receiver is not ready; a new input
// byte is taken only in the idle state, once the queue is empty. The last byte
// of a string is followed by an end-marker beat. After a failed escape the held
// bytes are put back in the queue and decoded again. Reset returns the decoder
// to text mode, zero count and a capacity of 65535.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsu_in_if.sink      in_if,
  jsu_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  logic [15:0] cap_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {16'h0, cap_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      cap_q <= pwdata[15:0];
    end
  end

  // Effective limit: capacity capped at the counter's maximum.
  logic [COUNT_BITS-1:0] lim;
  always_comb begin
    if (COUNT_BITS >= 16) lim = COUNT_BITS'(cap_q);
    else if ({16'h0, cap_q} > 32'(CntMax)) lim = CntMax;
    else lim = COUNT_BITS'(cap_q);
  end

  jsu_pkg::state_e st_q, st_d;
  jsu_pkg::mode_e  mode_q, mode_d;
  logic [7:0]  held_q [6];
  logic [2:0]  hcnt_q, hcnt_d;
  logic [15:0] hi_q, hi_d, acc_q, acc_d;
  logic [COUNT_BITS-1:0] wc_q, wc_d;
  logic        last_q;

  // Work queue of bytes still to decode for the current input.
  logic [7:0]  q_q [jsu_pkg::QueueDepth];
  logic [7:0]  q_d [jsu_pkg::QueueDepth];
  logic [jsu_pkg::QueueAw:0] qn_q, qn_d;

  // Pending emit: up to four bytes.
  logic [7:0] eb_q [4];
  logic [7:0] eb_d [4];
  logic [2:0] en_q, en_d, ei_q, ei_d;

  logic [20:0] cp;
  logic [2:0]  cp_len;
  logic [7:0]  cb0, cb1, cb2, cb3;
  jsu_utf8_enc u_enc (.cp_i(cp), .len_o(cp_len), .b0_o(cb0), .b1_o(cb1),
                      .b2_o(cb2), .b3_o(cb3));

  logic [7:0]  c;
  logic        fin;
  logic [4:0]  d;
  logic [19:0] v;
  logic        do_cp, do_1, do_rep;
  logic [7:0]  one_b;
  logic [COUNT_BITS:0] room_sum;

  assign c   = q_q[0];
  assign fin = last_q && (qn_q == (jsu_pkg::QueueAw+1)'(1));
  assign d   = jsu_pkg::hex_value(c);
  assign v   = {acc_q, d[3:0]};
  assign in_if.ready = (st_q == jsu_pkg::ST_IDLE);

  always_comb begin
    st_d   = st_q;
    mode_d = mode_q;
    hcnt_d = hcnt_q;
    hi_d   = hi_q;
    acc_d  = acc_q;
    wc_d   = wc_q;
    q_d    = q_q;
    qn_d   = qn_q;
    eb_d   = eb_q;
    en_d   = en_q;
    ei_d   = ei_q;
    do_cp  = 1'b0;
    do_1   = 1'b0;
    do_rep = 1'b0;
    one_b  = c;
    cp     = {13'h0, c};
    room_sum = '0;
    out_if.valid     = 1'b0;
    out_if.out_byte  = 8'h00;
    out_if.out_valid = 1'b0;
    out_if.out_last  = 1'b0;
    out_if.out_count = wc_q;

    unique case (st_q)
      jsu_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          q_d[0] = in_if.in_byte;
          qn_d   = (jsu_pkg::QueueAw+1)'(1);
          st_d   = jsu_pkg::ST_FEED;
        end
      end
      jsu_pkg::ST_FEED: begin
        // Pop the head byte by default.
        for (int i = 0; i < jsu_pkg::QueueDepth - 1; i++) q_d[i] = q_q[i+1];
        qn_d = qn_q - 1'b1;
        case (mode_q)
          jsu_pkg::MODE_ESC: begin
            mode_d = jsu_pkg::MODE_NORMAL;
            do_1 = 1'b1;
            if (c == 8'h6E) one_b = 8'h0A;
            else if (c == 8'h72) one_b = 8'h0D;
            else if (c == 8'h74) one_b = 8'h09;
            else if (c == jsu_pkg::ChU && !fin) begin
              do_1   = 1'b0;
              mode_d = jsu_pkg::MODE_HEX;
              hcnt_d = '0;
              acc_d  = '0;
            end
          end
          jsu_pkg::MODE_HEX: begin
            if (d[4] || (hcnt_q < 3'd3 && fin)) begin
              do_1 = 1'b1;
              one_b = jsu_pkg::ChU;
              do_rep = 1'b1;
            end else if (hcnt_q < 3'd3) begin
              hcnt_d = hcnt_q + 1'b1;
              acc_d  = {acc_q[11:0], d[3:0]};
            end else begin
              hcnt_d = '0;
              mode_d = jsu_pkg::MODE_NORMAL;
              do_cp  = 1'b1;
              cp     = {5'h0, v[15:0]};
              if (v[15:0] >= jsu_pkg::SurHiLo && v[15:0] <= jsu_pkg::SurHiHi) begin
                if (fin) cp = jsu_pkg::Replace;
                else begin
                  do_cp  = 1'b0;
                  hi_d   = v[15:0];
                  mode_d = jsu_pkg::MODE_LOOK;
                end
              end else if (v[15:0] >= jsu_pkg::SurLoLo) begin
                if (v[15:0] <= jsu_pkg::SurLoHi) cp = jsu_pkg::Replace;
              end
            end
          end
          jsu_pkg::MODE_LOOK: begin
            logic ok;
            ok = (hcnt_q == 3'd0) ? (c == jsu_pkg::ChBslash) :
                 (hcnt_q == 3'd1) ? (c == jsu_pkg::ChU) : !d[4];
            if (!ok || (fin && hcnt_q < 3'd5)) begin
              do_cp = 1'b1;
              cp = jsu_pkg::Replace;
              do_rep = 1'b1;
            end else if (hcnt_q < 3'd5) begin
              if (hcnt_q == 3'd1) acc_d = '0;
              else if (hcnt_q >= 3'd2) acc_d = {acc_q[11:0], d[3:0]};
              hcnt_d = hcnt_q + 1'b1;
            end else if (v[15:0] >= jsu_pkg::SurLoLo && v[15:0] <= jsu_pkg::SurLoHi) begin
              hcnt_d = '0;
              mode_d = jsu_pkg::MODE_NORMAL;
              do_cp  = 1'b1;
              cp = jsu_pkg::SupBase + {1'b0, hi_q[9:0], v[9:0]};
            end else begin
              do_cp = 1'b1;
              cp = jsu_pkg::Replace;
              do_rep = 1'b1;
            end
          end
          default: begin
            mode_d = jsu_pkg::MODE_NORMAL;
            if (c == jsu_pkg::ChBslash && !fin) mode_d = jsu_pkg::MODE_ESC;
            else do_1 = 1'b1;
          end
        endcase
        if (do_rep) begin
          // Held bytes, then the current byte, then the rest of the queue.
          for (int i = 0; i < jsu_pkg::QueueDepth; i++) begin
            if (i < int'(hcnt_q)) q_d[i] = held_q[i];
            else if (i == int'(hcnt_q)) q_d[i] = c;
            else q_d[i] = q_q[i - int'(hcnt_q)];
          end
          qn_d   = qn_q + (jsu_pkg::QueueAw+1)'(hcnt_q);
          hcnt_d = '0;
          mode_d = jsu_pkg::MODE_NORMAL;
        end
        // Capacity check on the pending sequence.
        if (do_1) begin
          room_sum = {1'b0, wc_q} + (COUNT_BITS+1)'(1);
          eb_d[0] = one_b;
          en_d = (room_sum <= {1'b0, lim}) ? 3'd1 : 3'd0;
        end else if (do_cp) begin
          room_sum = {1'b0, wc_q} + (COUNT_BITS+1)'(cp_len);
          eb_d[0] = cb0; eb_d[1] = cb1; eb_d[2] = cb2; eb_d[3] = cb3;
          en_d = (room_sum <= {1'b0, lim}) ? cp_len : 3'd0;
        end else begin
          en_d = 3'd0;
        end
        ei_d = '0;
        st_d = jsu_pkg::ST_EMIT;
      end
      jsu_pkg::ST_EMIT: begin
        if (ei_q < en_q) begin
          out_if.valid     = 1'b1;
          out_if.out_byte  = eb_q[ei_q[1:0]];
          out_if.out_valid = 1'b1;
          out_if.out_count = wc_q + 1'b1;
          if (out_if.ready) begin
            wc_d = wc_q + 1'b1;
            ei_d = ei_q + 1'b1;
          end
        end else if (qn_q != '0) st_d = jsu_pkg::ST_FEED;
        else if (last_q) st_d = jsu_pkg::ST_MARK;
        else st_d = jsu_pkg::ST_IDLE;
      end
      jsu_pkg::ST_MARK: begin
        out_if.valid    = 1'b1;
        out_if.out_last = 1'b1;
        if (out_if.ready) begin
          wc_d   = '0;
          mode_d = jsu_pkg::MODE_NORMAL;
          hcnt_d = '0;
          hi_d   = '0;
          acc_d  = '0;
          st_d   = jsu_pkg::ST_WAIT;
        end
      end
      jsu_pkg::ST_WAIT: st_d = jsu_pkg::ST_IDLE;
      default: st_d = jsu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= jsu_pkg::ST_IDLE;
      mode_q <= jsu_pkg::MODE_NORMAL;
      hcnt_q <= '0;
      hi_q   <= '0;
      acc_q  <= '0;
      wc_q   <= '0;
      qn_q   <= '0;
      en_q   <= '0;
      ei_q   <= '0;
      last_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
      hi_q   <= hi_d;
      acc_q  <= acc_d;
      wc_q   <= wc_d;
      qn_q   <= qn_d;
      en_q   <= en_d;
      ei_q   <= ei_d;
      if (st_q == jsu_pkg::ST_IDLE && in_if.valid) last_q <= in_if.in_last;
    end
  end

  // Payload registers: queue, pending bytes and the held escape bytes.
  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    eb_q <= eb_d;
    if (st_q == jsu_pkg::ST_FEED && !do_rep && hcnt_d != hcnt_q && hcnt_d != '0) begin
      held_q[hcnt_q] <= c;
    end
  end
endmodule

@@ hw/rtl/jsu_utf8_enc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_utf8_enc
// Splits a code point into UTF-8 bytes and reports the sequence length.
// ----------------------------------------------------------------------------
module jsu_utf8_enc (
  input  logic [20:0] cp_i,
  output logic [2:0]  len_o,
  output logic [7:0]  b0_o,
  output logic [7:0]  b1_o,
  output logic [7:0]  b2_o,
  output logic [7:0]  b3_o
);
  always_comb begin
    b0_o = 8'h00;
    b1_o = 8'h00;
    b2_o = 8'h00;
    b3_o = 8'h00;
    if (cp_i < 21'h80) begin
      len_o = 3'd1;
      b0_o  = cp_i[7:0];
    end else if (cp_i < 21'h800) begin
      len_o = 3'd2;
      b0_o  = jsu_pkg::Lead2 | {3'b000, cp_i[10:6]};
      b1_o  = jsu_pkg::ContMark | {2'b00, cp_i[5:0]};
    end else if (cp_i < 21'h10000) begin
      len_o = 3'd3;
      b0_o  = jsu_pkg::Lead3 | {4'b0000, cp_i[15:12]};
      b1_o  = jsu_pkg::ContMark | {2'b00, cp_i[11:6]};
      b2_o  = jsu_pkg::ContMark | {2'b00, cp_i[5:0]};
    end else begin
      len_o = 3'd4;
      b0_o  = jsu_pkg::Lead4 | {5'b00000, cp_i[20:18]};
      b1_o  = jsu_pkg::ContMark | {2'b00, cp_i[17:12]};
      b2_o  = jsu_pkg::ContMark | {2'b00, cp_i[11:6]};
      b3_o  = jsu_pkg::ContMark | {2'b00, cp_i[5:0]};
    end
  end
endmodule

@@ sim/tb_json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Self-checking testbench for the JSON string unescaper. Strings are sent
// byte by byte. Each accepted byte runs through a behavioral decoder kept
// here, which queues the beats the block should produce. The queued beats are
// compared field by field with the output stream. The sender pauses in bursts,
// the receiver stalls on its own pattern, and the capacity register is
// reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;

  localparam int unsigned CntBits = 16;
  localparam int unsigned MaxBeats = 12;
  localparam int unsigned WdLimit = 5000;
  localparam int unsigned Drain = 40;
  localparam logic [2:0] AddrCapacity = 3'd0;

  typedef struct packed {
    logic [7:0]         data;
    logic               dvalid;
    logic               dlast;
    logic [CntBits-1:0] count;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  jsu_in_if in_if ();
  jsu_out_if #(.COUNT_BITS(CntBits)) out_if ();

  json_string_unescape_utf8 #(.COUNT_BITS(CntBits)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  // Decoder state mirrored here.
  logic [15:0]    capacity;
  jsu_pkg::mode_e dec_mode;
  logic [7:0]     held [6];
  int             held_n;
  logic [15:0]    high_half;
  logic [15:0]    accum;
  logic [15:0]    written;
  int             beats_this_byte;
  logic [7:0]     pending_bytes [$];
  beat_t          beats_due [$];

  int errors = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int beats_seen = 0;
  int idle_cycles = 0;
  int stall_style = 0;
  int burst_left = 0;

  function automatic void clear_decoder();
    dec_mode = jsu_pkg::MODE_NORMAL;
    held_n = 0;
    high_half = '0;
    accum = '0;
    written = '0;
  endfunction

  function automatic bit fits(int k);
    return int'(written) + k <= int'(capacity);
  endfunction

  function automatic void queue_beat(logic [7:0] b, logic v, logic l);
    beat_t e;
    if (beats_this_byte >= MaxBeats) return;
    e.data = b;
    e.dvalid = v;
    e.dlast = l;
    e.count = written;
    beats_due.push_back(e);
    beats_this_byte++;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    written = written + 16'd1;
    queue_beat(b, 1'b1, 1'b0);
  endfunction

  function automatic void put_single(logic [7:0] b);
    if (fits(1)) put_byte(b);
  endfunction

  function automatic void put_code_point(logic [20:0] cp);
    logic [7:0] seq [4];
    int n;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      seq[0] = 8'hC0 | {3'b0, cp[10:6]};
      seq[1] = 8'h80 | {2'b0, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = 8'hE0 | {4'b0, cp[15:12]};
      seq[1] = 8'h80 | {2'b0, cp[11:6]};
      seq[2] = 8'h80 | {2'b0, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = 8'hF0 | {5'b0, cp[20:18]};
      seq[1] = 8'h80 | {2'b0, cp[17:12]};
      seq[2] = 8'h80 | {2'b0, cp[11:6]};
      seq[3] = 8'h80 | {2'b0, cp[5:0]};
      n = 4;
    end
    // A sequence that does not fit whole is dropped.
    if (!fits(n)) return;
    for (int k = 0; k < n; k++) put_byte(seq[k]);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // The held bytes and the current one go back in front of the work list.
  function automatic void push_back_held(logic [7:0] c);
    pending_bytes.push_front(c);
    for (int i = held_n - 1; i >= 0; i--) pending_bytes.push_front(held[i]);
    held_n = 0;
    dec_mode = jsu_pkg::MODE_NORMAL;
  endfunction

  function automatic void decode_byte(logic [7:0] c, bit fin);
    int d;
    logic [19:0] v;
    bit ok;
    d = hex_digit(c);
    case (dec_mode)
      jsu_pkg::MODE_ESC: begin
        dec_mode = jsu_pkg::MODE_NORMAL;
        if (c == "n") put_single(8'h0A);
        else if (c == "r") put_single(8'h0D);
        else if (c == "t") put_single(8'h09);
        else if (c == jsu_pkg::ChU) begin
          if (fin) put_single(jsu_pkg::ChU);
          else begin
            dec_mode = jsu_pkg::MODE_HEX;
            held_n = 0;
            accum = '0;
          end
        end else put_single(c);
      end
      jsu_pkg::MODE_HEX: begin
        if (d < 0 || (held_n < 3 && fin)) begin
          put_single(jsu_pkg::ChU);
          push_back_held(c);
        end else if (held_n < 3) begin
          held[held_n] = c;
          held_n++;
          accum = {accum[11:0], d[3:0]};
        end else begin
          v = {accum, d[3:0]};
          held_n = 0;
          dec_mode = jsu_pkg::MODE_NORMAL;
          if (v >= 20'hD800 && v <= 20'hDBFF) begin
            if (fin) put_code_point(21'hFFFD);
            else begin
              high_half = v[15:0];
              dec_mode = jsu_pkg::MODE_LOOK;
            end
          end else if (v >= 20'hDC00 && v <= 20'hDFFF) put_code_point(21'hFFFD);
          else put_code_point({1'b0, v});
        end
      end
      jsu_pkg::MODE_LOOK: begin
        if (held_n == 0) ok = (c == jsu_pkg::ChBslash);
        else if (held_n == 1) ok = (c == jsu_pkg::ChU);
        else ok = (d >= 0);
        if (!ok || (fin && held_n < 5)) begin
          put_code_point(21'hFFFD);
          push_back_held(c);
        end else if (held_n < 5) begin
          if (held_n == 1) accum = '0;
          else if (held_n >= 2) accum = {accum[11:0], d[3:0]};
          held[held_n] = c;
          held_n++;
        end else begin
          v = {accum, d[3:0]};
          if (v >= 20'hDC00 && v <= 20'hDFFF) begin
            held_n = 0;
            dec_mode = jsu_pkg::MODE_NORMAL;
            put_code_point(21'h10000 + ((21'(high_half) - 21'hD800) << 10)
                           + (21'(v) - 21'hDC00));
          end else begin
            put_code_point(21'hFFFD);
            push_back_held(c);
          end
        end
      end
      default: begin
        dec_mode = jsu_pkg::MODE_NORMAL;
        if (c == jsu_pkg::ChBslash && !fin) dec_mode = jsu_pkg::MODE_ESC;
        else put_single(c);
      end
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    logic [7:0] c;
    beats_this_byte = 0;
    pending_bytes.delete();
    pending_bytes.push_back(b);
    while (pending_bytes.size() > 0) begin
      c = pending_bytes.pop_front();
      decode_byte(c, fin && pending_bytes.size() == 0);
    end
    if (fin) begin
      queue_beat(8'h00, 1'b0, 1'b1);
      clear_decoder();
    end
  endfunction

  // Sends one byte, with an occasional gap between bursts.
  task automatic send_byte(logic [7:0] b, logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_string(logic [7:0] s [$]);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(string t);
    logic [7:0] s [$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_string(s);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (beats_due.size() > 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrCapacity;
    pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'("0" + d);
    return ($urandom_range(0, 1) != 0) ? 8'("a" + d - 10) : 8'("A" + d - 10);
  endfunction

  function automatic void add_u_escape(ref logic [7:0] s [$], input logic [15:0] u);
    logic [7:0] h;
    s.push_back(jsu_pkg::ChBslash);
    s.push_back(jsu_pkg::ChU);
    for (int i = 3; i >= 0; i--) begin
      h = rand_hex();
      // Keep the chosen digit value but random letter case.
      if (u[i*4 +: 4] < 10) h = 8'("0" + u[i*4 +: 4]);
      else h = ($urandom_range(0, 1) != 0) ? 8'("a" + u[i*4 +: 4] - 10)
                                           : 8'("A" + u[i*4 +: 4] - 10);
      s.push_back(h);
    end
  endfunction

  // Builds a string mostly of well-formed escapes with some broken ones.
  function automatic void build_string(ref logic [7:0] s [$], input int pieces);
    logic [7:0] esc [7];
    int n;
    esc = '{"n", "r", "t", 8'h22, 8'h5C, "/", "q"};
    s.delete();
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1: s.push_back(8'($urandom_range(0, 255)));
        2: begin
          s.push_back(jsu_pkg::ChBslash);
          s.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : esc[$urandom_range(0, 6)]);
        end
        3: add_u_escape(s, 16'($urandom_range(0, 16'hFFFF)));
        4: add_u_escape(s, 16'($urandom_range(0, 16'h7FF)));
        5, 6: begin
          add_u_escape(s, 16'($urandom_range(16'hD800, 16'hDBFF)));
          add_u_escape(s, 16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        7: begin
          // Surrogate pair with a damaged low half.
          add_u_escape(s, 16'($urandom_range(16'hD800, 16'hDBFF)));
          add_u_escape(s, 16'($urandom_range(0, 16'hFFFF)));
          n = $urandom_range(0, 5);
          if (s.size() > n) s = s[0:s.size() - 1 - n];
        end
        8: begin
          // Short or bad hex run.
          add_u_escape(s, 16'($urandom_range(0, 16'hFFFF)));
          s[s.size() - $urandom_range(1, 4)] = 8'($urandom_range(0, 255));
        end
        default: s.push_back(jsu_pkg::ChBslash);
      endcase
    end
    if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_directed();
    stall_style = 0;
    send_text("\\n\\r\\t\\\"\\\\\\/\\q");
    send_text("\\u00e9\\u20AC\\ud83d\\uDE00");
    send_text("\\ud83dx\\udc00\\u12g4");
    send_text("\\ud83d\\u0041");
    send_text("\\ud83d");
    send_text("a\\u12");
    send_text("\\u");
    send_text("\\");
    send_string('{8'h00, 8'hFF});
  endtask

  task automatic test_random(int total, int max_pieces);
    logic [7:0] s [$];
    int target;
    target = bytes_sent + total;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 3) == 0) stall_style = $urandom_range(0, 2);
      build_string(s, $urandom_range(1, max_pieces));
      send_string(s);
    end
  endtask

  task automatic test_capacity();
    logic [15:0] caps [5];
    caps = '{16'd0, 16'd1, 16'd3, 16'd7, 16'hFFFF};
    foreach (caps[i]) begin
      wait_idle();
      write_capacity(caps[i]);
      test_random(20, 6);
    end
  endtask

  // Receiver stalls: none, random, or a fixed rhythm.
  int rhythm = 0;
  always @(posedge clk_i) begin
    rhythm <= (rhythm + 1) % 7;
    if (!rst_ni) out_if.ready <= 1'b0;
    else begin
      case (stall_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 9) > 3);
        default: out_if.ready <= (rhythm < 4);
      endcase
    end
  end

  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.out_byte, out_if.out_valid, out_if.out_last, out_if.out_count};
      beats_seen++;
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: got %p", got);
      end else begin
        want = beats_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"beat mismatch: byte exp %h got %h, valid exp %b got %b, ",
                      "last exp %b got %b, count exp %0d got %0d"},
                     want.data, got.data, want.dvalid, got.dvalid,
                     want.dlast, got.dlast, want.count, got.count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("json_string_unescape_utf8 regression: fail");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    capacity = 16'hFFFF;
    clear_decoder();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity();
    wait_idle();
    write_capacity(16'd5);
    test_directed();
    wait_idle();
    write_capacity(16'hFFFF);
    test_random(60, 10);
    wait_idle();
    if (beats_due.size() > 0) begin
      errors += beats_due.size();
      $display("%0d beats never arrived", beats_due.size());
    end
    $display("Sent %0d strings, %0d bytes; checked %0d output beats.",
             strings_sent, bytes_sent, beats_seen);
    $display("Capacities 0, 1, 3, 5, 7 and 65535 were used; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("json_string_unescape_utf8 regression: pass");
    end else begin
      $display("json_string_unescape_utf8 regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_stream_if.sv
hw/rtl/jsu_utf8_enc.sv
hw/rtl/json_string_unescape_utf8.sv
sim/tb_json_string_unescape_utf8.sv
